[rtl/spc_pkg.sv]
package spc_pkg;

  localparam int unsigned RATE_W = 32;
  localparam int unsigned MANT_W = 4;
  localparam int unsigned EXP_W  = 3;

  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [MANT_W-1:0] mant_t;
  typedef logic [EXP_W-1:0]  exp_t;

  localparam mant_t MANT_MIN    = 4'd1;
  localparam mant_t MANT_MAX    = 4'd15;
  localparam exp_t  EXP_MAX     = 3'd7;
  localparam rate_t OFFSET_INIT = 32'hFFFF_FFFF;
  localparam rate_t REF_CLOCK_RESET = 32'd250_000_000;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_FIT = 1'b1;

  // Quotient bits retired by the divider per cycle.
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DIV_STEPS      = RATE_W / DIV_RADIX_BITS;

  function automatic logic [7:0] pack_bits(input mant_t m, input exp_t e);
    pack_bits = {e[2:1], 1'b0, e[0], m};
  endfunction

endpackage

[rtl/spc_div.sv]
module spc_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  spc_pkg::rate_t dividend,
  input  spc_pkg::mant_t divisor,
  output logic           done,
  output spc_pkg::rate_t quotient
);

  localparam int unsigned CNT_W = $clog2(spc_pkg::DIV_STEPS);

  spc_pkg::rate_t dvd;
  spc_pkg::mant_t rem;
  spc_pkg::mant_t dsr;
  logic [CNT_W-1:0] cnt;
  logic busy;

  spc_pkg::rate_t dvd_next;
  spc_pkg::mant_t rem_next;

  // Restoring division, several quotient bits per cycle. The remainder stays
  // below the divisor, so one extra bit is enough for each trial subtraction.
  always_comb begin
    logic [spc_pkg::MANT_W:0] trial;
    logic [spc_pkg::DIV_RADIX_BITS-1:0] qnib;
    spc_pkg::mant_t r;
    r    = rem;
    qnib = '0;
    for (int i = 0; i < spc_pkg::DIV_RADIX_BITS; i++) begin
      trial = {r, dvd[spc_pkg::RATE_W-1-i]};
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
        qnib[spc_pkg::DIV_RADIX_BITS-1-i] = 1'b1;
      end
      r = trial[spc_pkg::MANT_W-1:0];
    end
    rem_next = r;
    dvd_next = {dvd[spc_pkg::RATE_W-spc_pkg::DIV_RADIX_BITS-1:0], qnib};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(spc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign quotient = dvd;

endmodule

[rtl/spi_clock_prescaler_search.sv]
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   target_rate_hz
// out       output     out_valid/out_ready status, mantissa, exponent, exact_hit,
//                                          rate_shortfall, packed_bits
// cfg       input      cfg_wr_en           cfg_wr_data (ref_clock_hz)
//
// Each mantissa takes one reference-clock division in the shared
// 4-bit-per-cycle divider, then steps the exponent from 0 to 7 by shifts and
// compares; after mantissa 15, or early on an exact hit, ST_FIN loads the
// result register. One request is in flight at a time; in_ready is high only
// when the search is idle. The result sits in an output register, so a new
// request is taken while the previous result waits; a finished search holds
// until that register is free. Reset is synchronous and loads ref_clock_hz
// with 250000000.
module spi_clock_prescaler_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] target_rate_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [3:0]  mantissa,
  output logic [2:0]  exponent,
  output logic        exact_hit,
  output logic [31:0] rate_shortfall,
  output logic [7:0]  packed_bits
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EXP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]     state;
  spc_pkg::rate_t ref_clock;
  spc_pkg::rate_t target;
  spc_pkg::rate_t rate;
  spc_pkg::rate_t best_off;
  spc_pkg::mant_t m;
  spc_pkg::exp_t  e;
  spc_pkg::mant_t best_m;
  spc_pkg::exp_t  best_e;
  logic           exact;

  logic           div_start;
  spc_pkg::mant_t div_divisor;
  logic           div_done;
  spc_pkg::rate_t div_quot;

  logic           accept;
  logic           next_mant;
  logic           out_free;
  logic           load_out;
  spc_pkg::rate_t shortfall;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign load_out  = (state == ST_FIN) && out_free;
  assign shortfall = target - rate;
  assign next_mant = (state == ST_EXP) && (rate != target) && (e == spc_pkg::EXP_MAX) &&
                     (m != spc_pkg::MANT_MAX);
  assign div_start   = accept || next_mant;
  assign div_divisor = accept ? spc_pkg::MANT_MIN : spc_pkg::mant_t'(m + 1'b1);

  // ref / (m << e) equals (ref / m) >> e, so one division serves all exponents.
  spc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ref_clock),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock <= spc_pkg::REF_CLOCK_RESET;
    end else if (cfg_wr_en) begin
      ref_clock <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (rate == target) begin
            state <= ST_FIN;
          end else if (e == spc_pkg::EXP_MAX) begin
            state <= (m == spc_pkg::MANT_MAX) ? ST_FIN : ST_DIV;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target   <= target_rate_hz;
      m        <= spc_pkg::MANT_MIN;
      best_m   <= '0;
      best_e   <= '0;
      best_off <= spc_pkg::OFFSET_INIT;
      exact    <= 1'b0;
    end
    if (state == ST_DIV && div_done) begin
      rate <= div_quot;
      e    <= '0;
    end
    if (state == ST_EXP) begin
      if (rate == target) begin
        best_m <= m;
        best_e <= e;
        exact  <= 1'b1;
      end else begin
        // Rates above the target are skipped; ties keep the earlier pair.
        if (rate < target && shortfall < best_off) begin
          best_off <= shortfall;
          best_m   <= m;
          best_e   <= e;
        end
        rate <= rate >> 1;
        e    <= e + 1'b1;
        if (next_mant) begin
          m <= spc_pkg::mant_t'(m + 1'b1);
        end
      end
    end
    if (load_out) begin
      if (best_m == '0) begin
        status         <= spc_pkg::STATUS_NO_FIT;
        mantissa       <= '0;
        exponent       <= '0;
        exact_hit      <= 1'b0;
        rate_shortfall <= '0;
        packed_bits    <= '0;
      end else begin
        status         <= spc_pkg::STATUS_OK;
        mantissa       <= best_m;
        exponent       <= best_e;
        exact_hit      <= exact;
        rate_shortfall <= exact ? '0 : best_off;
        packed_bits    <= spc_pkg::pack_bits(best_m, best_e);
      end
    end
  end

endmodule
